>>> rtl/core/md4_pkg.sv
// md4 digest core shared constants and step helper functions
package md4_pkg;

   localparam int WordWidth  = 32;
   localparam int BlockWords = 16;
   localparam int StepCount  = 48;

   localparam logic [31:0] IV_A = 32'h67452301;
   localparam logic [31:0] IV_B = 32'hefcdab89;
   localparam logic [31:0] IV_C = 32'h98badcfe;
   localparam logic [31:0] IV_D = 32'h10325476;
   localparam logic [31:0] K2   = 32'h5a827999;
   localparam logic [31:0] K3   = 32'h6ed9eba1;
   localparam logic [7:0]  PAD_BYTE = 8'h80;

   // message word used by a step
   function automatic logic [3:0] word_sel(input logic [5:0] j);
      logic [3:0] w;
      case (j[5:4])
         2'd0:    w = j[3:0];
         2'd1:    w = {j[1:0], j[3:2]};
         default: w = {j[0], j[1], j[2], j[3]};
      endcase
      return w;
   endfunction

   // rotate amount for a step
   function automatic logic [4:0] rot_amt(input logic [5:0] j);
      logic [4:0] s;
      case ({j[5:4], j[1:0]})
         4'h0, 4'h4, 4'h8: s = 5'd3;
         4'h1:             s = 5'd7;
         4'h2, 4'ha:       s = 5'd11;
         4'h3:             s = 5'd19;
         4'h5:             s = 5'd5;
         4'h6, 4'h9:       s = 5'd9;
         4'h7:             s = 5'd13;
         4'hb:             s = 5'd15;
         default:          s = 5'd3;
      endcase
      return s;
   endfunction

   function automatic logic [31:0] rotl(input logic [31:0] v, input logic [4:0] s);
      logic [63:0] dbl;
      dbl = {v, v} << s;
      return dbl[63:32];
   endfunction

endpackage

>>> rtl/core/md4_message_digest_core.sv
// md4 hash core: byte intake, block store in ram, 48 step compression, digest out
// a byte beat is taken while idle; the 64th byte of a block starts a compression
// (one read prefetch, 48 steps, one chain add) with ready low and no bytes taken;
// an end beat adds up to 18 padding writes and one or two compressions, then four
// digest beats; throughput is set by the single compression datapath on the ram
// reset clears control state, bit count and byte position, chain loads md4 iv
module md4_message_digest_core import md4_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_has_byte,
   input  logic        req_end_of_message,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_digest_word,
   output logic [1:0]  rsp_word_index,
   output logic        rsp_last_word
);

   typedef enum logic [2:0] {
      S_IDLE, S_PAD, S_ZERO, S_CRD, S_CMP, S_CADD, S_OUT
   } state_type;

   state_type   state_ff, state_in;
   logic [5:0]  pos_ff, pos_in;
   logic [63:0] cnt_ff, cnt_in;
   logic [31:0] acc_ff, acc_in;
   logic [31:0] chain_ff [4];
   logic [31:0] chain_in [4];
   logic [31:0] a_ff, b_ff, c_ff, d_ff, a_in, b_in, c_in, d_in;
   logic [5:0]  j_ff, j_in;
   logic [4:0]  wc_ff, wc_in;
   logic        pend_ff, pend_in, padded_ff, padded_in, final_ff, final_in;
   logic [1:0]  idx_ff, idx_in;

   logic                 wr_en;
   logic [3:0]           wr_addr, rd_addr;
   logic [WordWidth-1:0] wr_data, rd_data;
   logic [31:0]          f_val, k_val, t_sum, pad_word;

   md4_ram #(.Width(WordWidth), .Depth(BlockWords)) u_block_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // round function and step sum
   always_comb begin
      case (j_ff[5:4])
         2'd0: begin
            f_val = (b_ff & c_ff) | (~b_ff & d_ff);
            k_val = '0;
         end
         2'd1: begin
            f_val = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff);
            k_val = K2;
         end
         default: begin
            f_val = b_ff ^ c_ff ^ d_ff;
            k_val = K3;
         end
      endcase
      t_sum = a_ff + f_val + rd_data[31:0] + k_val;
   end

   // word holding the pad byte: earlier lanes kept, later lanes zero
   always_comb begin
      for (int l = 0; l < 4; l++) begin
         if (l < int'(pos_ff[1:0])) begin
            pad_word[8*l +: 8] = acc_ff[8*l +: 8];
         end else if (l == int'(pos_ff[1:0])) begin
            pad_word[8*l +: 8] = PAD_BYTE;
         end else begin
            pad_word[8*l +: 8] = 8'h00;
         end
      end
   end

   // next state
   always_comb begin
      state_in  = state_ff;
      pos_in    = pos_ff;
      cnt_in    = cnt_ff;
      acc_in    = acc_ff;
      chain_in  = chain_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      c_in      = c_ff;
      d_in      = d_ff;
      j_in      = j_ff;
      wc_in     = wc_ff;
      pend_in   = pend_ff;
      padded_in = padded_ff;
      final_in  = final_ff;
      idx_in    = idx_ff;
      wr_en     = 1'b0;
      wr_addr   = pos_ff[5:2];
      wr_data   = '0;
      rd_addr   = word_sel(j_ff + 6'd1);
      req_ready = (state_ff == S_IDLE);
      rsp_valid = (state_ff == S_OUT);

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_has_byte) begin
                  acc_in[8*pos_ff[1:0] +: 8] = req_data_byte;
                  cnt_in = cnt_ff + 64'd8;
                  pos_in = pos_ff + 6'd1;
                  if (pos_ff[1:0] == 2'd3) begin
                     wr_en   = 1'b1;
                     wr_data = {req_data_byte, acc_ff[23:0]};
                  end
                  if (pos_ff == 6'd63) begin
                     state_in = S_CRD;
                  end
               end
               if (req_end_of_message) begin
                  pend_in = 1'b1;
                  if (!(req_has_byte && pos_ff == 6'd63)) begin
                     state_in = S_PAD;
                  end
               end
            end
         end
         S_PAD: begin
            wr_en     = 1'b1;
            wr_data   = pad_word;
            padded_in = 1'b1;
            final_in  = (pos_ff[5:3] != 3'd7);
            wc_in     = {1'b0, pos_ff[5:2]} + 5'd1;
            state_in  = (pos_ff[5:2] == 4'd15) ? S_CRD : S_ZERO;
         end
         S_ZERO: begin
            wr_en   = 1'b1;
            wr_addr = wc_ff[3:0];
            if (final_ff && wc_ff[3:0] == 4'd14) begin
               wr_data = cnt_ff[31:0];
            end else if (final_ff && wc_ff[3:0] == 4'd15) begin
               wr_data = cnt_ff[63:32];
            end
            wc_in = wc_ff + 5'd1;
            if (wc_ff[3:0] == 4'd15) begin
               state_in = S_CRD;
            end
         end
         S_CRD: begin
            rd_addr  = word_sel(6'd0);
            a_in     = chain_ff[0];
            b_in     = chain_ff[1];
            c_in     = chain_ff[2];
            d_in     = chain_ff[3];
            j_in     = 6'd0;
            state_in = S_CMP;
         end
         S_CMP: begin
            a_in = d_ff;
            d_in = c_ff;
            c_in = b_ff;
            b_in = rotl(t_sum, rot_amt(j_ff));
            j_in = j_ff + 6'd1;
            if (j_ff == 6'(StepCount - 1)) begin
               state_in = S_CADD;
            end
         end
         S_CADD: begin
            chain_in[0] = chain_ff[0] + a_ff;
            chain_in[1] = chain_ff[1] + b_ff;
            chain_in[2] = chain_ff[2] + c_ff;
            chain_in[3] = chain_ff[3] + d_ff;
            if (!pend_ff) begin
               state_in = S_IDLE;
            end else if (!padded_ff) begin
               state_in = S_PAD;
            end else if (!final_ff) begin
               final_in = 1'b1;
               wc_in    = 5'd0;
               state_in = S_ZERO;
            end else begin
               idx_in   = 2'd0;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (rsp_ready) begin
               idx_in = idx_ff + 2'd1;
               if (idx_ff == 2'd3) begin
                  chain_in[0] = IV_A;
                  chain_in[1] = IV_B;
                  chain_in[2] = IV_C;
                  chain_in[3] = IV_D;
                  cnt_in    = '0;
                  pos_in    = '0;
                  pend_in   = 1'b0;
                  padded_in = 1'b0;
                  final_in  = 1'b0;
                  state_in  = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // result beat fields
   assign rsp_digest_word = chain_ff[idx_ff];
   assign rsp_word_index  = idx_ff;
   assign rsp_last_word   = (idx_ff == 2'd3);

   // state and datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         pos_ff      <= '0;
         cnt_ff      <= '0;
         chain_ff[0] <= IV_A;
         chain_ff[1] <= IV_B;
         chain_ff[2] <= IV_C;
         chain_ff[3] <= IV_D;
         j_ff        <= '0;
         wc_ff       <= '0;
         pend_ff     <= 1'b0;
         padded_ff   <= 1'b0;
         final_ff    <= 1'b0;
         idx_ff      <= '0;
      end else begin
         state_ff  <= state_in;
         pos_ff    <= pos_in;
         cnt_ff    <= cnt_in;
         chain_ff  <= chain_in;
         j_ff      <= j_in;
         wc_ff     <= wc_in;
         pend_ff   <= pend_in;
         padded_ff <= padded_in;
         final_ff  <= final_in;
         idx_ff    <= idx_in;
      end
      acc_ff <= acc_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      c_ff   <= c_in;
      d_ff   <= d_in;
   end

   // no input taken while digest beats are pending
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("input taken during digest output");

   // block store is never written while the compression reads it
   a_no_write_cmp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CMP || state_ff == S_CRD) |-> !wr_en)
      else $error("block store written during compression");

   // digest is only shown once padding has completed
   a_out_padded: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (pend_ff && padded_ff && final_ff))
      else $error("digest shown before padding done");

   // a full block always leads into a compression
   a_block_cmp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_has_byte && pos_ff == 6'd63) |=> state_ff == S_CRD)
      else $error("full block did not start compression");

endmodule

>>> rtl/core/md4_ram.sv
// generic single write port ram with registered read
module md4_ram #(
   parameter int Width = 32,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
